### rtl/core/octahedral_tangent_space_packer_assert.svh
// assertion macros for the octahedral tangent-space packer
// used by the top level; relies on clk and rst in the including module
`ifndef OCTAHEDRAL_TANGENT_SPACE_PACKER_ASSERT_SVH
`define OCTAHEDRAL_TANGENT_SPACE_PACKER_ASSERT_SVH

// antecedent implies consequent, checked on every clock outside reset
`define OTS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ots assertion failed");

// expression holds on every clock outside reset
`define OTS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ots assertion failed");

`endif

### rtl/core/ots_pkg.sv
// shared types, widths and constants of the octahedral tangent-space packer
// no dependencies
`default_nettype none

package ots_pkg;

  localparam int FIELD_BITS           = 10;
  localparam int FIELD_MAX            = (1 << FIELD_BITS) - 1;
  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int COMP_W               = 16;
  localparam int L1_W                 = 17;
  localparam int NUM_W                = 28;
  localparam int DEN_W                = 18;
  localparam int BITS_PER_DIV         = 2;
  localparam int DIV_STAGES           = FIELD_BITS / BITS_PER_DIV;
  localparam int DEC_W                = 12;
  localparam int ROOT_SCALE           = 6;
  localparam int SQ_W                 = 32;
  localparam int ROOT_PER_STAGE       = 2;
  localparam int ROOT_STAGES          = SQ_W / 2 / ROOT_PER_STAGE;
  localparam int LEN_W                = 16;
  localparam int TB_W                 = 36;
  localparam int DOT_W                = 54;
  localparam int CORD_W               = 56;
  localparam int ANG_W                = 34;
  localparam int QUANT_LAT            = 1 + DIV_STAGES;
  localparam int BASIS_LAT            = 2 + ROOT_STAGES + 5;
  localparam int CORDIC_EXTRA_LAT     = 2;

  localparam logic [1:0] WIND_SET   = 2'd3;
  localparam logic [1:0] WIND_CLEAR = 2'd0;

  typedef struct packed {
    logic                     kind;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;
    logic signed [COMP_W-1:0] tangent_x;
    logic signed [COMP_W-1:0] tangent_y;
    logic signed [COMP_W-1:0] tangent_z;
    logic                     tangent_w_is_one;
  } vertex_t;

  typedef struct packed {
    logic [31:0] packed_word;
    logic        degenerate;
  } result_t;

  typedef struct packed {
    logic                     valid;
    logic                     kind;
    logic signed [COMP_W-1:0] tx;
    logic signed [COMP_W-1:0] ty;
    logic signed [COMP_W-1:0] tz;
    logic                     w_one;
    logic                     degen;
    logic [FIELD_BITS-1:0]    qu;
    logic [FIELD_BITS-1:0]    qv;
  } quant_t;

  typedef struct packed {
    logic                    valid;
    logic                    kind;
    logic                    w_one;
    logic                    degen;
    logic [FIELD_BITS-1:0]   qu;
    logic [FIELD_BITS-1:0]   qv;
    logic signed [DOT_W-1:0] dt;
    logic signed [DOT_W-1:0] db;
  } basis_t;

  // arctangent of 2^-i, full turn = 2^32, truncated
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2E;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000028;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000002;
      5'd29:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ots_quant.sv
// normal projection, octahedral fold and pipelined 10-bit quantizing divider
// depends on ots_pkg
`default_nettype none

module ots_quant (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ots_pkg::vertex_t vertex,
  output ots_pkg::quant_t q
);

  localparam int NW = ots_pkg::NUM_W;
  localparam int DW = ots_pkg::DEN_W;
  localparam int LW = ots_pkg::L1_W;
  localparam int FB = ots_pkg::FIELD_BITS;
  localparam int CW = ots_pkg::COMP_W;
  localparam int NS = ots_pkg::DIV_STAGES;
  localparam int BP = ots_pkg::BITS_PER_DIV;

  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic signed [CW-1:0] tz;
    logic                 w_one;
    logic                 degen;
    logic [NW-1:0]        rem_u;
    logic [NW-1:0]        rem_v;
    logic [DW-1:0]        den;
    logic [FB-1:0]        qu;
    logic [FB-1:0]        qv;
  } div_t;

  div_t st [NS+1];
  div_t st0_next;

  function automatic logic [LW-1:0] mag16(input logic signed [CW-1:0] v);
    logic signed [LW-1:0] e;
    e = LW'(v);
    return e[LW-1] ? LW'(-e) : LW'(e);
  endfunction

  always_comb begin
    logic [LW-1:0]       ax, ay, az, l1, ls;
    logic signed [LW+1:0] nu, nv, lsig;
    logic [DW-1:0]       su, sv;
    ax = mag16(vertex.normal_x);
    ay = mag16(vertex.normal_y);
    az = mag16(vertex.normal_z);
    l1 = ax + ay + az;
    ls = (l1 == '0) ? LW'(1) : l1;
    lsig = $signed({2'b00, ls});
    if (!vertex.normal_z[CW-1]) begin
      nu = (LW+2)'(vertex.normal_x);
      nv = (LW+2)'(vertex.normal_y);
    end else begin
      nu = vertex.normal_x[CW-1] ? -$signed({2'b00, ls - ay}) : $signed({2'b00, ls - ay});
      nv = vertex.normal_y[CW-1] ? -$signed({2'b00, ls - ax}) : $signed({2'b00, ls - ax});
    end
    su = DW'(nu + lsig);
    sv = DW'(nv + lsig);
    st0_next.valid = in_valid;
    st0_next.kind  = vertex.kind;
    st0_next.tx    = vertex.tangent_x;
    st0_next.ty    = vertex.tangent_y;
    st0_next.tz    = vertex.tangent_z;
    st0_next.w_one = vertex.tangent_w_is_one;
    st0_next.degen = (l1 == '0);
    st0_next.rem_u = NW'({su, {FB{1'b0}}}) - NW'(su) + NW'(ls);
    st0_next.rem_v = NW'({sv, {FB{1'b0}}}) - NW'(sv) + NW'(ls);
    st0_next.den   = DW'({ls, 1'b0});
    st0_next.qu    = '0;
    st0_next.qv    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0] <= st0_next;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_div
    div_t nxt;

    always_comb begin
      nxt = st[g];
      for (int j = 0; j < BP; j++) begin
        logic [NW-1:0] trial;
        trial = NW'(st[g].den) << (FB - 1 - (BP * g + j));
        if (nxt.rem_u >= trial) begin
          nxt.rem_u = nxt.rem_u - trial;
          nxt.qu[FB - 1 - (BP * g + j)] = 1'b1;
        end
        if (nxt.rem_v >= trial) begin
          nxt.rem_v = nxt.rem_v - trial;
          nxt.qv[FB - 1 - (BP * g + j)] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[g+1].valid <= 1'b0;
      end else begin
        st[g+1] <= nxt;
      end
    end
  end

  always_comb begin
    q.valid = st[NS].valid;
    q.kind  = st[NS].kind;
    q.tx    = st[NS].tx;
    q.ty    = st[NS].ty;
    q.tz    = st[NS].tz;
    q.w_one = st[NS].w_one;
    q.degen = st[NS].degen;
    q.qu    = st[NS].qu;
    q.qv    = st[NS].qv;
  end

endmodule

`default_nettype wire

### rtl/core/ots_basis.sv
// normal decode, pipelined square root, orthonormal basis and tangent dot products
// depends on ots_pkg
`default_nettype none

module ots_basis (
  input  logic            clk,
  input  logic            rst,
  input  ots_pkg::quant_t q,
  output ots_pkg::basis_t b
);

  localparam int DEC = ots_pkg::DEC_W;
  localparam int RS  = ots_pkg::ROOT_SCALE;
  localparam int SQ  = ots_pkg::SQ_W;
  localparam int RW  = SQ + 1;
  localparam int RPS = ots_pkg::ROOT_PER_STAGE;
  localparam int RNS = ots_pkg::ROOT_STAGES;
  localparam int LNW = ots_pkg::LEN_W;
  localparam int XW  = DEC + RS;
  localparam int WW  = LNW + 2;
  localparam int PW  = WW + LNW;
  localparam int TW  = ots_pkg::TB_W;
  localparam int CW  = ots_pkg::COMP_W;
  localparam int MW  = CW + TW;
  localparam int DTW = ots_pkg::DOT_W;
  localparam logic signed [DEC-1:0] FMAX = DEC'(ots_pkg::FIELD_MAX);

  typedef struct packed {
    logic                    valid;
    logic                    kind;
    logic signed [CW-1:0]    tx;
    logic signed [CW-1:0]    ty;
    logic signed [CW-1:0]    tz;
    logic                    w_one;
    logic                    degen;
    logic [ots_pkg::FIELD_BITS-1:0] qu;
    logic [ots_pkg::FIELD_BITS-1:0] qv;
  } pass_t;

  typedef struct packed {
    pass_t                 ps;
    logic [SQ-1:0]         rem;
    logic [RW-1:0]         r;
    logic signed [DEC-1:0] dx;
    logic signed [DEC-1:0] dy;
    logic signed [DEC-1:0] dz;
  } root_t;

  function automatic logic [DEC-1:0] mag12(input logic signed [DEC-1:0] v);
    return v[DEC-1] ? DEC'(-v) : DEC'(v);
  endfunction

  pass_t                 qp, p1, p3, p4, p5, p6;
  logic signed [DEC-1:0] dx1, dy1, dz1, dx1_next, dy1_next, dz1_next;
  root_t                 rt [RNS+1];
  root_t                 rt0_next;

  logic signed [XW-1:0]  xs3, ys3;
  logic [WW-1:0]         wsum3;
  logic [LNW-1:0]        len3;
  logic                  spos3, spos4;

  logic [PW-1:0]         pp4;
  logic signed [TW-1:0]  xx4, yy4, xy4;
  logic signed [TW:0]    xw4, yw4;
  logic signed [TW-1:0]  t0, t1, t2, b0, b1, b2;
  logic signed [MW-1:0]  m0, m1, m2, m3, m4, m5;

  always_comb begin
    qp.valid = q.valid;
    qp.kind  = q.kind;
    qp.tx    = q.tx;
    qp.ty    = q.ty;
    qp.tz    = q.tz;
    qp.w_one = q.w_one;
    qp.degen = q.degen;
    qp.qu    = q.qu;
    qp.qv    = q.qv;
  end

  // decode the quantized normal back onto the octahedron
  always_comb begin
    logic signed [DEC-1:0] a, c, dz;
    a  = $signed({1'b0, q.qu, 1'b0}) - FMAX;
    c  = $signed({1'b0, q.qv, 1'b0}) - FMAX;
    dz = FMAX - $signed(mag12(a)) - $signed(mag12(c));
    dz1_next = dz;
    if (!dz[DEC-1]) begin
      dx1_next = a;
      dy1_next = c;
    end else begin
      dx1_next = a[DEC-1] ? -(FMAX - $signed(mag12(c))) : (FMAX - $signed(mag12(c)));
      dy1_next = c[DEC-1] ? -(FMAX - $signed(mag12(a))) : (FMAX - $signed(mag12(a)));
    end
  end

  always_ff @(posedge clk) begin
    dx1 <= dx1_next;
    dy1 <= dy1_next;
    dz1 <= dz1_next;
    if (rst) begin
      p1.valid <= 1'b0;
    end else begin
      p1 <= qp;
    end
  end

  always_comb begin
    logic signed [2*DEC-1:0] sqs;
    sqs = (2*DEC)'(dx1) * (2*DEC)'(dx1) + (2*DEC)'(dy1) * (2*DEC)'(dy1)
        + (2*DEC)'(dz1) * (2*DEC)'(dz1);
    rt0_next.ps  = p1;
    rt0_next.rem = SQ'({sqs[SQ-2*RS-1:0], {(2*RS){1'b0}}});
    rt0_next.r   = '0;
    rt0_next.dx  = dx1;
    rt0_next.dy  = dy1;
    rt0_next.dz  = dz1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt[0].ps.valid <= 1'b0;
    end else begin
      rt[0] <= rt0_next;
    end
  end

  for (genvar g = 0; g < RNS; g++) begin : g_root
    root_t nxt;

    always_comb begin
      nxt = rt[g];
      for (int j = 0; j < RPS; j++) begin
        logic [RW-1:0] bitv, trial;
        bitv  = RW'(1) << (SQ - 2 - 2 * (RPS * g + j));
        trial = nxt.r + bitv;
        if ({1'b0, nxt.rem} >= trial) begin
          nxt.rem = nxt.rem - trial[SQ-1:0];
          nxt.r   = (nxt.r >> 1) + bitv;
        end else begin
          nxt.r   = nxt.r >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt[g+1].ps.valid <= 1'b0;
      end else begin
        rt[g+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    len3  <= rt[RNS].r[LNW-1:0];
    xs3   <= $signed({rt[RNS].dx, {RS{1'b0}}});
    ys3   <= $signed({rt[RNS].dy, {RS{1'b0}}});
    wsum3 <= WW'(rt[RNS].r[LNW-1:0]) + WW'({mag12(rt[RNS].dz), {RS{1'b0}}});
    spos3 <= !rt[RNS].dz[DEC-1];
    if (rst) begin
      p3.valid <= 1'b0;
    end else begin
      p3 <= rt[RNS].ps;
    end
  end

  always_ff @(posedge clk) begin
    spos4 <= spos3;
    pp4   <= PW'(wsum3) * PW'(len3);
    xx4   <= TW'(xs3) * TW'(xs3);
    yy4   <= TW'(ys3) * TW'(ys3);
    xy4   <= TW'(xs3) * TW'(ys3);
    xw4   <= (TW+1)'(xs3) * $signed({{(TW+1-WW){1'b0}}, wsum3});
    yw4   <= (TW+1)'(ys3) * $signed({{(TW+1-WW){1'b0}}, wsum3});
    if (rst) begin
      p4.valid <= 1'b0;
    end else begin
      p4 <= p3;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] ps, d0, d1;
    ps = $signed({{(TW-PW){1'b0}}, pp4});
    d0 = ps - xx4;
    d1 = ps - yy4;
    t0 <= d0;
    t1 <= -xy4;
    t2 <= spos4 ? -TW'(xw4) : TW'(xw4);
    b0 <= spos4 ? -xy4 : xy4;
    b1 <= spos4 ? d1 : -d1;
    b2 <= -TW'(yw4);
    if (rst) begin
      p5.valid <= 1'b0;
    end else begin
      p5 <= p4;
    end
  end

  always_ff @(posedge clk) begin
    m0 <= MW'(p5.tx) * MW'(t0);
    m1 <= MW'(p5.ty) * MW'(t1);
    m2 <= MW'(p5.tz) * MW'(t2);
    m3 <= MW'(p5.tx) * MW'(b0);
    m4 <= MW'(p5.ty) * MW'(b1);
    m5 <= MW'(p5.tz) * MW'(b2);
    if (rst) begin
      p6.valid <= 1'b0;
    end else begin
      p6 <= p5;
    end
  end

  always_ff @(posedge clk) begin
    b.kind  <= p6.kind;
    b.w_one <= p6.w_one;
    b.degen <= p6.degen;
    b.qu    <= p6.qu;
    b.qv    <= p6.qv;
    b.dt    <= DTW'(m0) + DTW'(m1) + DTW'(m2);
    b.db    <= DTW'(m3) + DTW'(m4) + DTW'(m5);
    if (rst) begin
      b.valid <= 1'b0;
    end else begin
      b.valid <= p6.valid;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ots_cordic.sv
// vectoring cordic, one step per stage, angle quantization and word packing
// depends on ots_pkg
`default_nettype none

module ots_cordic #(
  parameter int STEPS = ots_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  ots_pkg::basis_t  b,
  output logic             done,
  output ots_pkg::result_t result
);

  localparam int FB  = ots_pkg::FIELD_BITS;
  localparam int CW  = ots_pkg::CORD_W;
  localparam int AW  = ots_pkg::ANG_W;
  localparam int TTW = 33;
  localparam int QPW = TTW + FB;
  localparam logic signed [AW-1:0] QUARTER   = AW'(64'sh4000_0000);
  localparam logic [TTW-1:0]       HALF_TURN = 33'h0_8000_0000;
  localparam logic [TTW-1:0]       FULL_TURN = 33'h1_0000_0000;

  typedef struct packed {
    logic                 valid;
    logic                 kind;
    logic                 w_one;
    logic                 degen;
    logic                 zero;
    logic [FB-1:0]        qu;
    logic [FB-1:0]        qv;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cst_t;

  cst_t cs [STEPS+1];
  cst_t cs0_next;

  // pre-rotate into the right half plane
  always_comb begin
    logic signed [CW-1:0] xi, yi;
    xi = CW'(b.dt);
    yi = CW'(b.db);
    cs0_next.valid = b.valid;
    cs0_next.kind  = b.kind;
    cs0_next.w_one = b.w_one;
    cs0_next.degen = b.degen;
    cs0_next.zero  = (b.dt == '0) && (b.db == '0);
    cs0_next.qu    = b.qu;
    cs0_next.qv    = b.qv;
    if (xi[CW-1]) begin
      if (!yi[CW-1]) begin
        cs0_next.x   = yi;
        cs0_next.y   = -xi;
        cs0_next.ang = QUARTER;
      end else begin
        cs0_next.x   = -yi;
        cs0_next.y   = xi;
        cs0_next.ang = -QUARTER;
      end
    end else begin
      cs0_next.x   = xi;
      cs0_next.y   = yi;
      cs0_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0].valid <= 1'b0;
    end else begin
      cs[0] <= cs0_next;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    cst_t nxt;

    always_comb begin
      logic signed [CW-1:0] ddx, ddy;
      logic signed [AW-1:0] at;
      ddx = cs[g].y >>> g;
      ddy = cs[g].x >>> g;
      at  = $signed({2'b00, ots_pkg::atan_entry(5'(g))});
      nxt = cs[g];
      if (!cs[g].y[CW-1]) begin
        nxt.x   = cs[g].x + ddx;
        nxt.y   = cs[g].y - ddy;
        nxt.ang = cs[g].ang + at;
      end else begin
        nxt.x   = cs[g].x - ddx;
        nxt.y   = cs[g].y + ddy;
        nxt.ang = cs[g].ang - at;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[g+1].valid <= 1'b0;
      end else begin
        cs[g+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [AW-1:0] ang;
    logic signed [AW:0]   tt;
    logic [TTW-1:0]       tc;
    logic [QPW-1:0]       prod;
    logic [FB:0]          qa_w;
    logic [FB-1:0]        qa;
    logic [1:0]           wind;
    ang = cs[STEPS].zero ? '0 : cs[STEPS].ang;
    tt  = (AW+1)'(ang) + $signed({2'b00, HALF_TURN});
    if (tt[AW]) begin
      tc = '0;
    end else if (tt > $signed({2'b00, FULL_TURN})) begin
      tc = FULL_TURN;
    end else begin
      tc = tt[TTW-1:0];
    end
    prod = QPW'(tc) * QPW'(ots_pkg::FIELD_MAX) + QPW'(HALF_TURN);
    qa_w = prod[QPW-1:TTW-1];
    qa   = (qa_w > (FB+1)'(ots_pkg::FIELD_MAX)) ? FB'(ots_pkg::FIELD_MAX) : qa_w[FB-1:0];
    if (!cs[STEPS].kind) begin
      qa   = '0;
      wind = ots_pkg::WIND_SET;
    end else begin
      wind = cs[STEPS].w_one ? ots_pkg::WIND_SET : ots_pkg::WIND_CLEAR;
    end
    result.packed_word <= {wind, qa, cs[STEPS].qv, cs[STEPS].qu};
    result.degenerate  <= cs[STEPS].degen;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cs[STEPS].valid;
    end
  end

endmodule

`default_nettype wire

### rtl/core/octahedral_tangent_space_packer.sv
// octahedral tangent-space packer, top level
// depends on ots_pkg, ots_quant, ots_basis, ots_cordic and the assertion header
`default_nettype none

// Fully pipelined: one vertex may be started in every cycle and busy stays low.
// Each result appears on result with done high for exactly one cycle.
// The pipeline holds the 5-stage quantizing divider, the 8-stage square root of
// the basis renormalization and one cordic step per stage (CORDIC_STEPS, with a
// default of 16 steps).
// The receiver cannot stall; results must be taken as they appear.

`include "octahedral_tangent_space_packer_assert.svh"

module octahedral_tangent_space_packer #(
  parameter int CORDIC_STEPS = ots_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ots_pkg::vertex_t vertex,
  output logic             done,
  output ots_pkg::result_t result
);

  localparam int LATENCY = ots_pkg::QUANT_LAT + ots_pkg::BASIS_LAT + CORDIC_STEPS
                         + ots_pkg::CORDIC_EXTRA_LAT;

  ots_pkg::quant_t quant;
  ots_pkg::basis_t basis;

  assign busy = 1'b0;

  ots_quant u_quant (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .vertex   (vertex),
    .q        (quant)
  );

  ots_basis u_basis (
    .clk (clk),
    .rst (rst),
    .q   (quant),
    .b   (basis)
  );

  ots_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .b      (basis),
    .done   (done),
    .result (result)
  );

  `OTS_ASSERT_IMPLY(a_latency, start && !busy, ##LATENCY done)
  `OTS_ASSERT_IMPLY(a_degen_center, done && result.degenerate,
                    result.packed_word[9:0] == 10'd512 && result.packed_word[19:10] == 10'd512)
  `OTS_ASSERT_IMPLY(a_winding, done,
                    result.packed_word[31:30] == ots_pkg::WIND_SET ||
                    result.packed_word[31:30] == ots_pkg::WIND_CLEAR)
  `OTS_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

`default_nettype wire
